### design/fdgm_pkg.sv
// Package for the fragment duplicate group marker.
// Holds field widths and the fragment end, open group and decision record types.
// No dependencies.
`default_nettype none

package fdgm_pkg;

   localparam int LibraryWidth   = 7;
   localparam int ReferenceWidth = 8;
   localparam int PositionWidth  = 32;
   localparam int ScoreWidth     = 16;
   localparam int ReadWidth      = 63;

   // One fragment end as it moves from the input register to the decision logic.
   typedef struct packed {
      logic [LibraryWidth-1:0]          library_id;
      logic [ReferenceWidth-1:0]        reference_id;
      logic signed [PositionWidth-1:0]  map_position;
      logic                             strand;
      logic signed [ScoreWidth-1:0]     quality_score;
      logic [ReadWidth-1:0]             read_ident;
      logic                             pair_here;
   } end_type;

   // Open group as held by the top level.
   typedef struct packed {
      logic                             open;
      logic [LibraryWidth-1:0]          library_id;
      logic [ReferenceWidth-1:0]        reference_id;
      logic signed [PositionWidth-1:0]  map_position;
      logic                             strand;
      logic                             has_pair;
      logic signed [ScoreWidth-1:0]     best_score;
      logic [ReadWidth-1:0]             best_read;
   } group_type;

   // What the decision logic asks the top level to do with one end.
   typedef struct packed {
      logic                 emit;
      logic [ReadWidth-1:0] marked_read;
      logic                 load_group;
      logic                 load_best;
   } decision_type;

endpackage : fdgm_pkg

`default_nettype wire

### design/fragment_duplicate_group_marker.sv
// Top level of the fragment duplicate group marker.
// Holds the input register, the open group and the result register.
// Depends on fdgm_pkg and fdgm_decide.
`default_nettype none

// The block takes a sorted stream of fragment ends, one word per cycle, and
// gives out the read identifiers of the ends that it marks as duplicates. Ends
// with an equal key (library, reference, position and strand) form a group. If
// the first end of a group carries the pair flag, every end of that group is
// marked. Otherwise the highest score is kept, the earliest end winning a tie,
// and every other end is marked; when a later end beats the kept one, the
// identifier of the previously kept end is the one given out. Thus each input
// word causes either no result or exactly one, and marks leave in the order of
// the decisions rather than in stream order. The best end of a group without
// pairs is never reported, and nothing is emitted when a group closes. An end
// passes through two register stages: the input register, then the key and
// score compare against the open group, which writes the result register. One
// word is accepted in every cycle while the result side keeps taking words, so
// the throughput is one word per cycle; a stall on the result side holds both
// stages, and the input side still takes a word while the input register is
// empty.

module fragment_duplicate_group_marker
   import fdgm_pkg::*;
(
   input  wire                             clock,
   input  wire                             reset,

   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire [LibraryWidth-1:0]          req_library_id,
   input  wire [ReferenceWidth-1:0]        req_reference_id,
   input  wire signed [PositionWidth-1:0]  req_map_position,
   input  wire                             req_strand,
   input  wire signed [ScoreWidth-1:0]     req_quality_score,
   input  wire [ReadWidth-1:0]             req_read_ident,
   input  wire                             req_pair_here,

   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic [ReadWidth-1:0]            rsp_marked_read
);

   // Input register.
   logic         in_valid_ff;
   end_type      in_item_ff;

   // Open group; only the open flag needs a reset, the rest is read only
   // once a group is open.
   group_type    group_ff;
   group_type    group_in;

   // Result register.
   logic                 out_valid_ff;
   logic [ReadWidth-1:0] out_read_ff;

   decision_type decision;
   logic         advance;
   logic         process;

   // The pipeline moves whenever the result register is free or being emptied.
   assign advance   = !out_valid_ff || rsp_ready;
   assign process   = advance && in_valid_ff;
   assign req_ready = !in_valid_ff || advance;

   fdgm_decide u_decide (
      .item     (in_item_ff),
      .group    (group_ff),
      .decision (decision)
   );

   always_comb begin
      group_in = group_ff;
      if (decision.load_group) begin
         group_in.open         = 1'b1;
         group_in.library_id   = in_item_ff.library_id;
         group_in.reference_id = in_item_ff.reference_id;
         group_in.map_position = in_item_ff.map_position;
         group_in.strand       = in_item_ff.strand;
         group_in.has_pair     = in_item_ff.pair_here;
      end
      if (decision.load_best) begin
         group_in.best_score = in_item_ff.quality_score;
         group_in.best_read  = in_item_ff.read_ident;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff.library_id    <= req_library_id;
         in_item_ff.reference_id  <= req_reference_id;
         in_item_ff.map_position  <= req_map_position;
         in_item_ff.strand        <= req_strand;
         in_item_ff.quality_score <= req_quality_score;
         in_item_ff.read_ident    <= req_read_ident;
         in_item_ff.pair_here     <= req_pair_here;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff.open <= 1'b0;
      end else if (process) begin
         group_ff.open <= group_in.open;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         group_ff.library_id   <= group_in.library_id;
         group_ff.reference_id <= group_in.reference_id;
         group_ff.map_position <= group_in.map_position;
         group_ff.strand       <= group_in.strand;
         group_ff.has_pair     <= group_in.has_pair;
         group_ff.best_score   <= group_in.best_score;
         group_ff.best_read    <= group_in.best_read;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= process && decision.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (process && decision.emit) begin
         out_read_ff <= decision.marked_read;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_marked_read = out_read_ff;

endmodule : fragment_duplicate_group_marker

`default_nettype wire

### design/fdgm_decide.sv
// Decision logic of the fragment duplicate group marker.
// Compares one end with the open group and says what is marked and what is kept.
// Depends on fdgm_pkg.
`default_nettype none

module fdgm_decide
   import fdgm_pkg::*;
(
   input  end_type      item,
   input  group_type    group,
   output decision_type decision
);

   logic same_key;
   logic better;

   assign same_key = group.open
                     && (item.library_id   == group.library_id)
                     && (item.reference_id == group.reference_id)
                     && (item.map_position == group.map_position)
                     && (item.strand       == group.strand);

   // Strictly greater, so the earliest end keeps a tie.
   assign better = item.quality_score > group.best_score;

   always_comb begin
      decision.emit        = 1'b1;
      decision.marked_read = item.read_ident;
      decision.load_group  = 1'b0;
      decision.load_best   = 1'b0;
      if (!same_key) begin
         // A new group opens; its first end is the best so far.
         decision.emit       = item.pair_here;
         decision.load_group = 1'b1;
         decision.load_best  = 1'b1;
      end else if (group.has_pair) begin
         decision.emit = 1'b1;
      end else if (better) begin
         // The previous best is now beaten and gets the mark.
         decision.marked_read = group.best_read;
         decision.load_best   = 1'b1;
      end
   end

endmodule : fdgm_decide

`default_nettype wire
